// File: rtl/core/lz4fd_pkg.sv
// LZ4 frame deframer: shared types and constants.
// No dependencies; imported by the parser, the result register and the top level.
`timescale 1ns / 1ps

package lz4fd_pkg;

    typedef enum logic [10:0] {
        PH_MAGIC   = 11'b000_0000_0001,
        PH_FLG     = 11'b000_0000_0010,
        PH_BD      = 11'b000_0000_0100,
        PH_CSIZE   = 11'b000_0000_1000,
        PH_DICT    = 11'b000_0001_0000,
        PH_HC      = 11'b000_0010_0000,
        PH_BSIZE   = 11'b000_0100_0000,
        PH_PAYLOAD = 11'b000_1000_0000,
        PH_BCHK    = 11'b001_0000_0000,
        PH_CCHK    = 11'b010_0000_0000,
        PH_IDLE    = 11'b100_0000_0000
    } phase_t;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_LZ4   = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_TRUNC     = 2'd3;

    localparam logic [31:0] FRAME_MAGIC = 32'h184D_2204;
    localparam logic [7:0]  BD_RSVD     = 8'h8F;
    localparam logic [30:0] BLOCK_BASE  = 31'(64 << 10);

    // bit positions in the packed frame flags
    localparam int FL_DICT  = 0;
    localparam int FL_CCHK  = 1;
    localparam int FL_CSIZE = 2;
    localparam int FL_BCHK  = 3;
    localparam int FL_INDEP = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic        raw_block;
        logic        block_last;
        logic        independent_blocks;
        logic        has_block_checksum;
        logic        has_content_checksum;
        logic [2:0]  size_code;
        logic        frame_csize_valid;
        logic [63:0] frame_csize;
        logic [31:0] dictionary_id;
        logic [1:0]  status;
    } lz4fd_result_t;

    // largest block length allowed for a size code of 4..7
    function automatic logic [30:0] block_limit(input logic [2:0] code);
        return BLOCK_BASE << {code[1:0], 1'b0};
    endfunction

endpackage

// File: rtl/core/lz4fd_ifs.sv
// LZ4 frame deframer: valid/ready channel interfaces for requests and results.
// Depends on nothing; the top level connects through these.
`timescale 1ns / 1ps

interface lz4fd_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface lz4fd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        raw_block;
    logic        block_last;
    logic        independent_blocks;
    logic        has_block_checksum;
    logic        has_content_checksum;
    logic [2:0]  size_code;
    logic        frame_csize_valid;
    logic [63:0] frame_csize;
    logic [31:0] dictionary_id;
    logic [1:0]  status;

    modport source (
        output valid, output kind, output out_byte, output raw_block,
        output block_last, output independent_blocks, output has_block_checksum,
        output has_content_checksum, output size_code, output frame_csize_valid,
        output frame_csize, output dictionary_id, output status,
        input ready
    );
    modport sink (
        input valid, input kind, input out_byte, input raw_block,
        input block_last, input independent_blocks, input has_block_checksum,
        input has_content_checksum, input size_code, input frame_csize_valid,
        input frame_csize, input dictionary_id, input status,
        output ready
    );
endinterface

// File: rtl/core/lz4fd_parser.sv
// LZ4 frame deframer: frame state machine, field gathering and result forming.
// Depends on lz4fd_pkg.
`timescale 1ns / 1ps

module lz4fd_parser
    import lz4fd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          func,
    input  logic [7:0]    data_byte,
    output logic          res_valid,
    output lz4fd_result_t res
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] gather_reg, gather_next;
    logic [4:0]  flags_reg, flags_next;
    logic [2:0]  max_code_reg, max_code_next;
    logic [63:0] csize_reg, csize_next;
    logic [31:0] dict_reg, dict_next;
    logic [22:0] left_reg, left_next;
    logic        raw_reg, raw_next;

    logic [63:0] gather_ins;
    logic        done4;
    logic        done8;
    logic [31:0] size_word;
    logic [22:0] left_dec;
    phase_t      after_block;
    phase_t      after_bd;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic        r_raw;
    logic        r_last;
    logic [1:0]  r_status;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            gather_ins[8*k +: 8] = (idx_reg == 3'(k)) ? data_byte : gather_reg[8*k +: 8];
        end
    end

    assign done4       = (idx_reg == 3'd3);
    assign done8       = (idx_reg == 3'd7);
    assign size_word   = gather_ins[31:0];
    assign left_dec    = left_reg - 23'd1;
    assign after_block = flags_reg[FL_BCHK] ? PH_BCHK : PH_BSIZE;
    assign after_bd    = flags_reg[FL_CSIZE] ? PH_CSIZE :
                         (flags_reg[FL_DICT] ? PH_DICT : PH_HC);

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        gather_next   = gather_reg;
        flags_next    = flags_reg;
        max_code_next = max_code_reg;
        csize_next    = csize_reg;
        dict_next     = dict_reg;
        left_next     = left_reg;
        raw_next      = raw_reg;
        res_valid     = 1'b0;
        r_kind        = KIND_PAYLOAD;
        r_byte        = 8'd0;
        r_raw         = 1'b0;
        r_last        = 1'b0;
        r_status      = ST_OK;

        if (accept && phase_reg != PH_IDLE)
        begin
            if (func)
            begin
                phase_next = PH_IDLE;
                res_valid  = 1'b1;
                if (phase_reg == PH_CCHK)
                begin
                    r_kind = KIND_END;
                end
                else
                begin
                    r_kind   = KIND_ERROR;
                    r_status = ST_TRUNC;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_MAGIC, PH_DICT, PH_BSIZE, PH_BCHK, PH_CCHK:
                    begin
                        if (done4)
                        begin
                            gather_next = 64'd0;
                            idx_next    = 3'd0;
                        end
                        else
                        begin
                            gather_next = gather_ins;
                            idx_next    = idx_reg + 3'd1;
                        end
                        if (done4)
                        begin
                            case (phase_reg)
                                PH_MAGIC:
                                begin
                                    if (gather_ins[31:0] != FRAME_MAGIC)
                                    begin
                                        phase_next = PH_IDLE;
                                        res_valid  = 1'b1;
                                        r_kind     = KIND_ERROR;
                                        r_status   = ST_NOT_LZ4;
                                    end
                                    else
                                    begin
                                        phase_next = PH_FLG;
                                    end
                                end
                                PH_DICT:
                                begin
                                    dict_next  = gather_ins[31:0];
                                    phase_next = PH_HC;
                                end
                                PH_BSIZE:
                                begin
                                    if (size_word == 32'd0)
                                    begin
                                        if (flags_reg[FL_CCHK])
                                        begin
                                            phase_next = PH_CCHK;
                                        end
                                        else
                                        begin
                                            phase_next = PH_IDLE;
                                            res_valid  = 1'b1;
                                            r_kind     = KIND_END;
                                        end
                                    end
                                    else if (size_word[30:0] > block_limit(max_code_reg))
                                    begin
                                        phase_next = PH_IDLE;
                                        res_valid  = 1'b1;
                                        r_kind     = KIND_ERROR;
                                        r_status   = ST_TOO_LARGE;
                                    end
                                    else
                                    begin
                                        raw_next  = size_word[31];
                                        left_next = size_word[22:0];
                                        if (size_word[22:0] == 23'd0)
                                        begin
                                            phase_next = after_block;
                                        end
                                        else
                                        begin
                                            phase_next = PH_PAYLOAD;
                                        end
                                    end
                                end
                                PH_BCHK:
                                begin
                                    phase_next = PH_BSIZE;
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                    res_valid  = 1'b1;
                                    r_kind     = KIND_END;
                                end
                            endcase
                        end
                    end
                    PH_FLG:
                    begin
                        if (data_byte[7:6] != 2'b01 || data_byte[1])
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            r_kind     = KIND_ERROR;
                            r_status   = ST_NOT_LZ4;
                        end
                        else
                        begin
                            flags_next = {data_byte[5:2], data_byte[0]};
                            phase_next = PH_BD;
                        end
                    end
                    PH_BD:
                    begin
                        if ((data_byte & BD_RSVD) != 8'd0 || !data_byte[6])
                        begin
                            phase_next = PH_IDLE;
                            res_valid  = 1'b1;
                            r_kind     = KIND_ERROR;
                            r_status   = ST_NOT_LZ4;
                        end
                        else
                        begin
                            max_code_next = data_byte[6:4];
                            phase_next    = after_bd;
                        end
                    end
                    PH_CSIZE:
                    begin
                        if (done8)
                        begin
                            gather_next = 64'd0;
                            idx_next    = 3'd0;
                            csize_next  = gather_ins;
                            phase_next  = flags_reg[FL_DICT] ? PH_DICT : PH_HC;
                        end
                        else
                        begin
                            gather_next = gather_ins;
                            idx_next    = idx_reg + 3'd1;
                        end
                    end
                    PH_HC:
                    begin
                        phase_next = PH_BSIZE;
                        res_valid  = 1'b1;
                        r_kind     = KIND_HEADER;
                    end
                    PH_PAYLOAD:
                    begin
                        left_next = left_dec;
                        res_valid = 1'b1;
                        r_kind    = KIND_PAYLOAD;
                        r_byte    = data_byte;
                        r_raw     = raw_reg;
                        r_last    = (left_dec == 23'd0);
                        if (left_dec == 23'd0)
                        begin
                            phase_next = after_block;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res.kind                 = r_kind;
        res.out_byte             = r_byte;
        res.raw_block            = r_raw;
        res.block_last           = r_last;
        res.independent_blocks   = flags_reg[FL_INDEP];
        res.has_block_checksum   = flags_reg[FL_BCHK];
        res.has_content_checksum = flags_reg[FL_CCHK];
        res.size_code            = max_code_reg;
        res.frame_csize_valid    = flags_reg[FL_CSIZE];
        res.frame_csize          = csize_reg;
        res.dictionary_id        = dict_reg;
        res.status               = r_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            idx_reg      <= 3'd0;
            gather_reg   <= 64'd0;
            flags_reg    <= 5'd0;
            max_code_reg <= 3'd0;
            csize_reg    <= 64'd0;
            dict_reg     <= 32'd0;
            left_reg     <= 23'd0;
            raw_reg      <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            gather_reg   <= gather_next;
            flags_reg    <= flags_next;
            max_code_reg <= max_code_next;
            csize_reg    <= csize_next;
            dict_reg     <= dict_next;
            left_reg     <= left_next;
            raw_reg      <= raw_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |=> phase_reg == PH_IDLE)
        else $error("deframer left the idle phase before reset");

    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> left_reg != 23'd0)
        else $error("payload phase with no bytes left");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> !res_valid)
        else $error("result produced while idle");

    // a stream end inside the content size leaves the index where it stopped
    a_short_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_CSIZE && phase_reg != PH_IDLE |-> !idx_reg[2])
        else $error("field index beyond four bytes outside content size");

    a_last_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == KIND_PAYLOAD && res.block_last
        |=> phase_reg == PH_BSIZE || phase_reg == PH_BCHK)
        else $error("last payload byte did not end the block");
`endif

endmodule

// File: rtl/core/lz4fd_out_stage.sv
// LZ4 frame deframer: result register between the parser and the output channel.
// Depends on lz4fd_pkg.
`timescale 1ns / 1ps

module lz4fd_out_stage
    import lz4fd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  lz4fd_result_t res,
    input  logic          ready,
    output logic          valid,
    output logic          free,
    output lz4fd_result_t res_q
);

    logic          valid_reg;
    logic          valid_next;
    lz4fd_result_t data_reg;

    assign free       = !valid_reg || ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !ready);
    assign valid      = valid_reg;
    assign res_q      = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res;
        end
    end

endmodule

// File: rtl/core/lz4_frame_deframer.sv
// LZ4 frame deframer top level: parser plus result register.
// Depends on lz4fd_pkg, lz4fd_ifs, lz4fd_parser and lz4fd_out_stage.
//
//   channel   interface        carries
//   frame     lz4fd_in_if      func, data_byte (one frame byte or stream end)
//   result    lz4fd_out_if     kind, payload byte, header fields, status
//
// One request per cycle while frame.ready is high; a result, where a request makes one, shows in the cycle after it.
// frame.ready is low only while a held result is not taken.
// rst_n clears the parser to expect the magic number and empties the result register.
// After frame end or an error, requests are taken and dropped until reset.
`timescale 1ns / 1ps

module lz4_frame_deframer
    import lz4fd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lz4fd_in_if.sink     frame,
    lz4fd_out_if.source  result
);

    logic          accept;
    logic          res_valid;
    logic          free;
    lz4fd_result_t res;
    lz4fd_result_t res_q;

    assign frame.ready = free;
    assign accept      = frame.valid && free;

    lz4fd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (frame.func),
        .data_byte (frame.data_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    lz4fd_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (res_valid),
        .res   (res),
        .ready (result.ready),
        .valid (result.valid),
        .free  (free),
        .res_q (res_q)
    );

    assign result.kind                 = res_q.kind;
    assign result.out_byte             = res_q.out_byte;
    assign result.raw_block            = res_q.raw_block;
    assign result.block_last           = res_q.block_last;
    assign result.independent_blocks   = res_q.independent_blocks;
    assign result.has_block_checksum   = res_q.has_block_checksum;
    assign result.has_content_checksum = res_q.has_content_checksum;
    assign result.size_code            = res_q.size_code;
    assign result.frame_csize_valid    = res_q.frame_csize_valid;
    assign result.frame_csize          = res_q.frame_csize;
    assign result.dictionary_id        = res_q.dictionary_id;
    assign result.status               = res_q.status;

endmodule
